// ----- rtl/core/skt_pkg.sv -----
package skt_pkg;

	localparam int MODE_W      = 2;
	localparam int KEY_W       = 31;
	localparam int STATUS_W    = 2;
	localparam int COUNT_W     = 7;
	localparam int S_TDATA_W   = 40;
	localparam int M_TDATA_W   = 16;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_FIND   = 2'd1,
		OP_DELETE = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_NOT_FOUND = 2'd1,
		STS_FULL      = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PLACE,
		ST_DONE
	} state_t;

endpackage

// ----- rtl/core/sorted_key_table.sv -----
// Sorted key table: holds up to TABLE_DEPTH 31-bit keys in descending order in one
// synchronous memory (one write port, one read port with a registered read). Each
// request is an insert (new key lands ahead of its equals, refused with "full" when
// the table is full), a find, or a delete of the whole run of equal keys; mode 3
// acts as find. Exactly one response follows each request, carrying the status and
// the entry count after the operation (count masked to 7 bits). One request is
// worked at a time. The read port streams one entry per cycle: a find stops at
// the first match, a delete reads every entry, and an insert reads from the last
// entry down to the slot that the new key lands in. An insert into a full table,
// and any request on an empty table, go straight to the done state with no read.
// A finished request holds in the done state for as long as the previous response
// still waits on the master side. The next request is taken while a response
// still waits on the master side.
module sorted_key_table
	import skt_pkg::*;
#(
	parameter int TABLE_DEPTH = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // [1:0] mode, [32:2] key, [39:33] zero
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata    // [1:0] status, [8:2] entry_count, [15:9] zero
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
	localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);
	localparam logic [IDX_W-1:0] ONE_IDX   = IDX_W'(1);

	// Key store
	logic [KEY_W-1:0] mem [TABLE_DEPTH];

	state_t           state_q, state_d;
	op_t              op_q, op_d;
	logic [KEY_W-1:0] key_q, key_d;
	logic [IDX_W-1:0] rd_addr_q, rd_addr_d;
	logic [CNT_W-1:0] rd_left_q, rd_left_d;
	logic [CNT_W-1:0] del_q, del_d;
	logic [CNT_W-1:0] fill_q, fill_d;
	status_t          status_q, status_d;

	// Read return stage
	logic             v_s1;
	logic             last_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [KEY_W-1:0] rdata_s1;

	logic             rd_en;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [KEY_W-1:0] wr_data;
	logic             out_load;

	logic [MODE_W-1:0]    s_mode;
	logic [KEY_W-1:0]     s_key;
	logic [CNT_W-1:0]     fill_m1;
	logic                 key_eq;
	logic                 key_gt;
	logic [CNT_W-1:0]     del_inc;
	logic [CNT_W+6:0]     fill_ext;

	assign s_mode   = s_tdata[MODE_W-1:0];
	assign s_key    = s_tdata[MODE_W+KEY_W-1:MODE_W];
	assign fill_m1  = fill_q - ONE_CNT;
	assign key_eq   = (rdata_s1 == key_q);
	assign key_gt   = (rdata_s1 > key_q);
	assign del_inc  = del_q + (key_eq ? ONE_CNT : '0);
	assign fill_ext = {7'd0, fill_q};

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d   = state_q;
		op_d      = op_q;
		key_d     = key_q;
		rd_addr_d = rd_addr_q;
		rd_left_d = rd_left_q;
		del_d     = del_q;
		fill_d    = fill_q;
		status_d  = status_q;
		rd_en     = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = '0;
		wr_data   = key_q;
		out_load  = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					key_d = s_key;
					del_d = '0;
					case (s_mode)
						OP_INSERT: op_d = OP_INSERT;
						OP_DELETE: op_d = OP_DELETE;
						default:   op_d = OP_FIND;
					endcase
					if (op_d == OP_INSERT) begin
						if (fill_q == DEPTH_CNT) begin
							// refuse: table stays as it is
							status_d = STS_FULL;
							state_d  = ST_DONE;
						end else if (fill_q == '0) begin
							wr_en    = 1'b1;
							wr_addr  = '0;
							wr_data  = s_key;
							fill_d   = fill_q + ONE_CNT;
							status_d = STS_OK;
							state_d  = ST_DONE;
						end else begin
							// walk down from the last entry, shifting as we go
							rd_addr_d = fill_m1[IDX_W-1:0];
							rd_left_d = fill_q;
							state_d   = ST_SCAN;
						end
					end else begin
						if (fill_q == '0) begin
							status_d = STS_NOT_FOUND;
							state_d  = ST_DONE;
						end else begin
							rd_addr_d = '0;
							rd_left_d = fill_q;
							state_d   = ST_SCAN;
						end
					end
				end
			end

			ST_SCAN: begin
				if (rd_left_q != '0) begin
					rd_en     = 1'b1;
					rd_left_d = rd_left_q - ONE_CNT;
					rd_addr_d = (op_q == OP_INSERT) ? rd_addr_q - ONE_IDX : rd_addr_q + ONE_IDX;
				end
				if (v_s1) begin
					case (op_q)
						OP_INSERT: begin
							wr_en   = 1'b1;
							wr_addr = idx_s1 + ONE_IDX;
							if (key_gt) begin
								wr_data  = key_q;
								fill_d   = fill_q + ONE_CNT;
								status_d = STS_OK;
								state_d  = ST_DONE;
							end else begin
								wr_data = rdata_s1;
								if (last_s1) begin
									state_d = ST_PLACE;
								end
							end
						end
						OP_DELETE: begin
							// drop the run of equals, pull the tail forward over it
							del_d = del_inc;
							if (!key_eq) begin
								wr_en   = 1'b1;
								wr_addr = idx_s1 - del_q[IDX_W-1:0];
								wr_data = rdata_s1;
							end
							if (last_s1) begin
								status_d = (del_inc == '0) ? STS_NOT_FOUND : STS_OK;
								fill_d   = fill_q - del_inc;
								state_d  = ST_DONE;
							end
						end
						default: begin
							if (key_eq) begin
								status_d = STS_OK;
								state_d  = ST_DONE;
							end else if (last_s1) begin
								status_d = STS_NOT_FOUND;
								state_d  = ST_DONE;
							end
						end
					endcase
				end
			end

			ST_PLACE: begin
				wr_en    = 1'b1;
				wr_addr  = '0;
				wr_data  = key_q;
				fill_d   = fill_q + ONE_CNT;
				status_d = STS_OK;
				state_d  = ST_DONE;
			end

			ST_DONE: begin
				if (!m_tvalid || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			fill_q    <= '0;
			rd_left_q <= '0;
			del_q     <= '0;
			v_s1      <= 1'b0;
			m_tvalid  <= 1'b0;
		end else begin
			state_q   <= state_d;
			fill_q    <= fill_d;
			rd_left_q <= rd_left_d;
			del_q     <= del_d;
			v_s1      <= rd_en;
			if (out_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		op_q      <= op_d;
		key_q     <= key_d;
		rd_addr_q <= rd_addr_d;
		status_q  <= status_d;
		idx_s1    <= rd_addr_q;
		last_s1   <= (rd_left_q == ONE_CNT);
		if (out_load) begin
			m_tdata <= {7'd0, fill_ext[COUNT_W-1:0], status_q};
		end
	end

	// Memory: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr_q];
		end
	end

endmodule
